### hw/rtl/assert_macros.svh
// assertion macros used by oute_seq.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("%m: never-condition hit");
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error("%m: implication failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error("%m: next-cycle check failed");
`else
`define ASSERT_NEVER(lbl, clk, rst, cond)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### hw/rtl/oute_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package oute_pkg;

   // character codes
   localparam logic [7:0] CH_ESC   = 8'd27;
   localparam logic [7:0] CH_K     = 8'd107;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_BSL   = 8'd92;
   localparam logic [7:0] CH_ZERO  = 8'd48;
   localparam logic [7:0] CH_SEVEN = 8'd55;

   // input transaction payload
   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   // result transaction payload
   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       hold_overflow;
   } rsp_type;

   // one result handed from the sequencer to the output stage
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } emit_type;

endpackage

`default_nettype wire

### hw/rtl/oute_hold_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module oute_hold_mem #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port, data holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/oute_rsp_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module oute_rsp_stage
   import oute_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire emit_type emit,
   output logic          can_emit,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output rsp_type       rsp_data
);

   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;

   // slot is free when empty or being taken this cycle
   assign can_emit = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      if (emit.valid) begin
         rsp_data_ff <= emit.data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### hw/rtl/oute_seq.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module oute_seq
   import oute_pkg::*;
#(
   parameter int HOLD_DEPTH = 32,
   parameter int AW         = 5,
   parameter int CW         = 6
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire req_type       req_data,
   output emit_type           emit,
   input  wire logic          can_emit,
   output logic               mem_wr_en,
   output logic      [AW-1:0] mem_wr_addr,
   output logic      [7:0]    mem_wr_data,
   output logic               mem_rd_en,
   output logic      [AW-1:0] mem_rd_addr,
   input  wire logic [7:0]    mem_rd_data
);

   typedef enum logic [13:0] {
      S_IDLE     = 14'b00000000000001,
      S_PARSE    = 14'b00000000000010,
      S_FIN      = 14'b00000000000100,
      S_FIN_NEXT = 14'b00000000001000,
      S_LIT      = 14'b00000000010000,
      S_APPEND   = 14'b00000000100000,
      S_APP_DLY  = 14'b00000001000000,
      S_KMOVE    = 14'b00000010000000,
      S_KPUT     = 14'b00000100000000,
      S_FL_RD    = 14'b00001000000000,
      S_FL_EMIT  = 14'b00010000000000,
      S_EOL      = 14'b00100000000000,
      S_END_DLY  = 14'b01000000000000,
      S_END_CLR  = 14'b10000000000000
   } state_type;

   typedef enum logic [2:0] {
      MODE_NORMAL = 3'b001,
      MODE_BSL    = 3'b010,
      MODE_DIGITS = 3'b100
   } mode_type;

   typedef enum logic [1:0] {
      FL_OVF  = 2'd0,
      FL_KEEP = 2'd1,
      FL_EOL  = 2'd2
   } fl_kind_type;

   localparam logic [CW-1:0] DEPTH_C = CW'(HOLD_DEPTH);

   state_type   state_ff, state_in;
   mode_type    mode_ff, mode_in;
   fl_kind_type fl_kind_ff, fl_kind_in;
   logic [7:0]    byte_ff, byte_in;
   logic          last_ff, last_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic [7:0]    accum_ff, accum_in;
   logic [2:0]    digit_ff [3];
   logic [2:0]    digit_in [3];
   logic          after_esc_ff, after_esc_in;
   logic          mark_ff, mark_in;
   logic          dly_valid_ff, dly_valid_in;
   logic [7:0]    dly_byte_ff, dly_byte_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [7:0]    app_byte_ff, app_byte_in;
   logic          in_fin_ff, in_fin_in;
   logic          reproc_ff, reproc_in;
   logic          fin_raw_ff, fin_raw_in;
   logic [1:0]    fin_idx_ff, fin_idx_in;

   logic          is_oct;
   logic [2:0]    oct_val;
   logic          printable;
   logic [2:0]    digit_sel;
   logic [CW-1:0] fl_limit;
   logic [CW-1:0] count_m1;
   state_type     app_ret;

   // byte classification
   assign is_oct    = (byte_ff >= CH_ZERO) && (byte_ff <= CH_SEVEN);
   assign oct_val   = byte_ff[2:0];
   assign printable = (accum_ff >= CH_SPACE) && !accum_ff[7] && (accum_ff != CH_BSL);
   assign digit_sel = (fin_idx_ff == 2'd0) ? digit_ff[0] :
                      (fin_idx_ff == 2'd1) ? digit_ff[1] : digit_ff[2];
   assign count_m1  = count_ff - CW'(1);
   assign fl_limit  = (fl_kind_ff == FL_KEEP) ? count_m1 : count_ff;
   assign app_ret   = in_fin_ff ? S_FIN_NEXT : S_EOL;

   assign req_ready = (state_ff == S_IDLE);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      fl_kind_in   = fl_kind_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      cnt_in       = cnt_ff;
      accum_in     = accum_ff;
      digit_in     = digit_ff;
      after_esc_in = after_esc_ff;
      mark_in      = mark_ff;
      dly_valid_in = dly_valid_ff;
      dly_byte_in  = dly_byte_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      app_byte_in  = app_byte_ff;
      in_fin_in    = in_fin_ff;
      reproc_in    = reproc_ff;
      fin_raw_in   = fin_raw_ff;
      fin_idx_in   = fin_idx_ff;
      emit         = '0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = count_ff[AW-1:0];
      mem_wr_data  = app_byte_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = idx_ff[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               byte_in  = req_data.in_byte;
               last_in  = req_data.in_last;
               state_in = S_PARSE;
            end
         end

         // escape parser
         S_PARSE: begin
            unique case (mode_ff)
               MODE_BSL: begin
                  if (is_oct) begin
                     accum_in    = {5'd0, oct_val};
                     digit_in[0] = oct_val;
                     cnt_in      = 2'd1;
                     mode_in     = MODE_DIGITS;
                     state_in    = S_EOL;
                  end else begin
                     mode_in = MODE_NORMAL;
                  end
               end
               MODE_DIGITS: begin
                  if (is_oct && (cnt_ff != 2'd3)) begin
                     accum_in = {accum_ff[4:0], oct_val};
                     for (int i = 0; i < 3; i++) begin
                        if (cnt_ff == 2'(i)) begin
                           digit_in[i] = oct_val;
                        end
                     end
                     cnt_in = cnt_ff + 2'd1;
                     if (cnt_ff == 2'd2) begin
                        reproc_in = 1'b0;
                        state_in  = S_FIN;
                     end else begin
                        state_in = S_EOL;
                     end
                  end else begin
                     reproc_in = 1'b1;
                     state_in  = S_FIN;
                  end
               end
               MODE_NORMAL: begin
                  if (byte_ff == CH_BSL) begin
                     mode_in  = MODE_BSL;
                     state_in = S_EOL;
                  end else begin
                     state_in = S_LIT;
                  end
               end
               default: begin
                  mode_in = MODE_NORMAL;
               end
            endcase
         end

         // finish an escape: re-emit the text or pass the raw byte
         S_FIN: begin
            in_fin_in  = 1'b1;
            fin_idx_in = 2'd0;
            if (printable) begin
               fin_raw_in   = 1'b0;
               app_byte_in  = CH_BSL;
               after_esc_in = 1'b0;
            end else begin
               fin_raw_in  = 1'b1;
               app_byte_in = accum_ff;
            end
            state_in = S_APPEND;
         end

         S_FIN_NEXT: begin
            if (!fin_raw_ff && (fin_idx_ff < cnt_ff)) begin
               app_byte_in = {CH_ZERO[7:3], digit_sel};
               fin_idx_in  = fin_idx_ff + 2'd1;
               state_in    = S_APPEND;
            end else begin
               if (fin_raw_ff) begin
                  after_esc_in = (accum_ff == CH_ESC);
                  // decoded esc drops everything from the mark on
                  if ((accum_ff == CH_ESC) && mark_ff) begin
                     count_in = '0;
                     mark_in  = 1'b0;
                  end
               end
               mode_in   = MODE_NORMAL;
               cnt_in    = 2'd0;
               accum_in  = 8'd0;
               in_fin_in = 1'b0;
               reproc_in = 1'b0;
               state_in  = reproc_ff ? S_PARSE : S_EOL;
            end
         end

         // literal byte, 'k' after esc sets the mark or moves it
         S_LIT: begin
            if (after_esc_ff && (byte_ff == CH_K)) begin
               if (mark_ff) begin
                  if (count_ff != '0) begin
                     fl_kind_in = FL_KEEP;
                     idx_in     = '0;
                     state_in   = S_FL_RD;
                  end else begin
                     state_in = S_KPUT;
                  end
               end else begin
                  mark_in = 1'b1;
                  if (dly_valid_ff) begin
                     mem_wr_en    = 1'b1;
                     mem_wr_addr  = '0;
                     mem_wr_data  = dly_byte_ff;
                     count_in     = CW'(1);
                     dly_valid_in = 1'b0;
                  end else begin
                     count_in = '0;
                  end
                  state_in = S_KPUT;
               end
            end else begin
               app_byte_in = byte_ff;
               state_in    = S_APPEND;
            end
         end

         S_KMOVE: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = '0;
            mem_wr_data = mem_rd_data;
            count_in    = CW'(1);
            state_in    = S_KPUT;
         end

         S_KPUT: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = CH_K;
            count_in    = count_ff + CW'(1);
            state_in    = S_EOL;
         end

         // append to hold memory or through the one-byte delay
         S_APPEND: begin
            if (mark_ff) begin
               if (count_ff == DEPTH_C) begin
                  fl_kind_in = FL_OVF;
                  idx_in     = '0;
                  state_in   = S_FL_RD;
               end else begin
                  mem_wr_en = 1'b1;
                  count_in  = count_ff + CW'(1);
                  state_in  = app_ret;
               end
            end else begin
               state_in = S_APP_DLY;
            end
         end

         S_APP_DLY: begin
            if (!dly_valid_ff || can_emit) begin
               if (dly_valid_ff) begin
                  emit.valid         = 1'b1;
                  emit.data.out_byte = dly_byte_ff;
               end
               dly_byte_in  = app_byte_ff;
               dly_valid_in = 1'b1;
               state_in     = app_ret;
            end
         end

         // flush loop over the hold memory
         S_FL_RD: begin
            if (idx_ff < fl_limit) begin
               mem_rd_en = 1'b1;
               state_in  = S_FL_EMIT;
            end else begin
               case (fl_kind_ff)
                  FL_OVF: begin
                     count_in = '0;
                     mark_in  = 1'b0;
                     state_in = S_APP_DLY;
                  end
                  FL_KEEP: begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = count_m1[AW-1:0];
                     state_in    = S_KMOVE;
                  end
                  default: begin
                     count_in = '0;
                     state_in = S_END_CLR;
                  end
               endcase
            end
         end

         S_FL_EMIT: begin
            if (can_emit) begin
               emit.valid              = 1'b1;
               emit.data.out_byte      = mem_rd_data;
               emit.data.out_last      = (fl_kind_ff == FL_EOL) && (idx_ff == count_m1);
               emit.data.hold_overflow = (fl_kind_ff == FL_OVF);
               idx_in                  = idx_ff + CW'(1);
               state_in                = S_FL_RD;
            end
         end

         // line end: close a pending escape, then drain
         S_EOL: begin
            if (!last_ff) begin
               state_in = S_IDLE;
            end else begin
               unique case (mode_ff)
                  MODE_BSL: begin
                     app_byte_in = CH_BSL;
                     in_fin_in   = 1'b0;
                     mode_in     = MODE_NORMAL;
                     state_in    = S_APPEND;
                  end
                  MODE_DIGITS: begin
                     reproc_in = 1'b0;
                     state_in  = S_FIN;
                  end
                  default: begin
                     state_in = S_END_DLY;
                  end
               endcase
            end
         end

         S_END_DLY: begin
            if (!dly_valid_ff || can_emit) begin
               if (dly_valid_ff) begin
                  emit.valid         = 1'b1;
                  emit.data.out_byte = dly_byte_ff;
                  emit.data.out_last = (count_ff == '0);
               end
               dly_valid_in = 1'b0;
               if (count_ff != '0) begin
                  fl_kind_in = FL_EOL;
                  idx_in     = '0;
                  state_in   = S_FL_RD;
               end else begin
                  state_in = S_END_CLR;
               end
            end
         end

         S_END_CLR: begin
            mode_in      = MODE_NORMAL;
            cnt_in       = 2'd0;
            accum_in     = 8'd0;
            after_esc_in = 1'b0;
            mark_in      = 1'b0;
            state_in     = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_NORMAL;
         cnt_ff       <= 2'd0;
         accum_ff     <= 8'd0;
         after_esc_ff <= 1'b0;
         mark_ff      <= 1'b0;
         dly_valid_ff <= 1'b0;
         count_ff     <= '0;
         in_fin_ff    <= 1'b0;
         reproc_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         cnt_ff       <= cnt_in;
         accum_ff     <= accum_in;
         after_esc_ff <= after_esc_in;
         mark_ff      <= mark_in;
         dly_valid_ff <= dly_valid_in;
         count_ff     <= count_in;
         in_fin_ff    <= in_fin_in;
         reproc_ff    <= reproc_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      last_ff     <= last_in;
      digit_ff    <= digit_in;
      dly_byte_ff <= dly_byte_in;
      idx_ff      <= idx_in;
      app_byte_ff <= app_byte_in;
      fin_raw_ff  <= fin_raw_in;
      fin_idx_ff  <= fin_idx_in;
      fl_kind_ff  <= fl_kind_in;
   end

   // held bytes only exist under an active mark, and the delay stage is empty then
   `ASSERT_NEVER(a_count_range, clock, reset, count_ff > DEPTH_C)
   `ASSERT_IMPLY(a_count_needs_mark, clock, reset, count_ff != '0, mark_ff)
   `ASSERT_NEVER(a_mark_excl_delay, clock, reset, mark_ff && dly_valid_ff)
   `ASSERT_IMPLY(a_emit_slot_free, clock, reset, emit.valid, can_emit)

endmodule

`default_nettype wire

### hw/rtl/octal_unescape_title_strip.sv
`timescale 1ns / 1ps
`default_nettype none

// A new byte is taken only in the idle state, once the previous byte has been fully
// processed. Plain bytes and re-emitted escape characters are appended one at a time,
// bytes drained from the hold memory take one read and one result each; the one-port
// hold memory and its registered read set the pace, and output stalls slow it further.
// An unheld byte waits in the one-byte delay until the next unheld byte or the line end.
// Reset: synchronous, active high; clears parse, mark and delay state, hold memory untouched.
module octal_unescape_title_strip
   import oute_pkg::*;
#(
   parameter int HOLD_DEPTH = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
   localparam int CW = $clog2(HOLD_DEPTH + 1);

   emit_type        emit;
   logic            can_emit;
   logic            mem_wr_en;
   logic [AW-1:0]   mem_wr_addr;
   logic [7:0]      mem_wr_data;
   logic            mem_rd_en;
   logic [AW-1:0]   mem_rd_addr;
   logic [7:0]      mem_rd_data;

   // parser and hold sequencer
   oute_seq #(
      .HOLD_DEPTH(HOLD_DEPTH),
      .AW        (AW),
      .CW        (CW)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .emit       (emit),
      .can_emit   (can_emit),
      .mem_wr_en  (mem_wr_en),
      .mem_wr_addr(mem_wr_addr),
      .mem_wr_data(mem_wr_data),
      .mem_rd_en  (mem_rd_en),
      .mem_rd_addr(mem_rd_addr),
      .mem_rd_data(mem_rd_data)
   );

   // hold memory
   oute_hold_mem #(
      .DEPTH(HOLD_DEPTH),
      .AW   (AW)
   ) u_hold_mem (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_en  (mem_rd_en),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

   // output register
   oute_rsp_stage u_rsp_stage (
      .clock    (clock),
      .reset    (reset),
      .emit     (emit),
      .can_emit (can_emit),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import oute_pkg::*;

   localparam int HOLD_DEPTH  = 32;
   localparam int STEP_CAP    = 40;
   localparam int MAX_REPORTS = 10;
   localparam logic [7:0] PRINT_MAX = 8'd127;
   localparam logic [7:0] LETTER_A  = 8'h61;
   localparam logic [7:0] LETTER_Q  = 8'h71;

   typedef enum logic [1:0] {SCAN_PLAIN, SCAN_BSL, SCAN_DIGITS} scan_mode_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   octal_unescape_title_strip #(
      .HOLD_DEPTH(HOLD_DEPTH)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // decoder state mirrored by the predictor
   scan_mode_type scan_mode;
   int            digit_total;
   logic [7:0]    octal_value;
   logic [2:0]    digit_vals[3];
   logic          esc_seen;
   logic          mark_on;
   logic          delay_valid;
   logic [7:0]    delay_byte;
   logic [7:0]    held[HOLD_DEPTH];
   int            held_count;

   rsp_type step_out[$];
   rsp_type decoded_queue[$];
   logic [7:0] line_buf[$];

   bit idle_on;
   int items_sent;
   int lines_sent;
   int results_checked;
   int overflow_seen;
   int mismatches;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("timeout with %0d results still pending", decoded_queue.size());
      $display("testbench NOT OK");
      $finish;
   end

   // ---------------- predictor ----------------

   function automatic void clear_decoder();
      scan_mode   = SCAN_PLAIN;
      digit_total = 0;
      octal_value = '0;
      esc_seen    = 1'b0;
      mark_on     = 1'b0;
      delay_valid = 1'b0;
      delay_byte  = '0;
      held_count  = 0;
   endfunction

   function automatic void push_out(logic [7:0] b, logic ovf);
      rsp_type r;
      if (step_out.size() >= STEP_CAP) return;
      r.out_byte      = b;
      r.out_last      = 1'b0;
      r.hold_overflow = ovf;
      step_out.push_back(r);
   endfunction

   function automatic void flush_held(logic ovf);
      for (int i = 0; i < held_count && i < HOLD_DEPTH; i++) push_out(held[i], ovf);
      held_count = 0;
   endfunction

   // byte enters the hold store while marked, else the one-byte delay
   function automatic void place_byte(logic [7:0] b);
      if (mark_on) begin
         if (held_count >= HOLD_DEPTH) begin
            flush_held(1'b1);
            mark_on = 1'b0;
         end else begin
            held[held_count] = b;
            held_count++;
            return;
         end
      end
      if (delay_valid) push_out(delay_byte, 1'b0);
      delay_byte  = b;
      delay_valid = 1'b1;
   endfunction

   // literal byte, with the mark set by a 'k' after a decoded escape
   function automatic void take_literal(logic [7:0] b);
      if (esc_seen && b == CH_K) begin
         if (mark_on) begin
            if (held_count > 0 && held_count <= HOLD_DEPTH) begin
               for (int i = 0; i + 1 < held_count; i++) push_out(held[i], 1'b0);
               held[0]    = held[held_count - 1];
               held_count = 1;
            end else begin
               held_count = 0;
            end
         end else begin
            held_count = 0;
            if (delay_valid) begin
               held[0]    = delay_byte;
               held_count = 1;
            end
            delay_valid = 1'b0;
            mark_on     = 1'b1;
         end
         held[held_count] = b;
         held_count++;
         return;
      end
      place_byte(b);
   endfunction

   // octal escape complete: re-emit printable text, else the raw byte
   function automatic void close_escape();
      logic [7:0] v;
      v = octal_value;
      if (v >= CH_SPACE && v <= PRINT_MAX && v != CH_BSL) begin
         place_byte(CH_BSL);
         for (int i = 0; i < digit_total && i < 3; i++)
            place_byte(CH_ZERO + 8'(digit_vals[i]));
         esc_seen = 1'b0;
      end else begin
         place_byte(v);
         esc_seen = (v == CH_ESC);
         if (esc_seen && mark_on) begin
            held_count = 0;
            mark_on    = 1'b0;
         end
      end
      scan_mode   = SCAN_PLAIN;
      digit_total = 0;
      octal_value = '0;
   endfunction

   function automatic void decode_byte(logic [7:0] b);
      logic is_oct;
      logic again;
      is_oct = (b >= CH_ZERO && b <= CH_SEVEN);
      again  = 1'b1;
      while (again) begin
         again = 1'b0;
         case (scan_mode)
            SCAN_BSL: begin
               if (is_oct) begin
                  octal_value   = b - CH_ZERO;
                  digit_vals[0] = 3'(b - CH_ZERO);
                  digit_total   = 1;
                  scan_mode     = SCAN_DIGITS;
               end else begin
                  scan_mode = SCAN_PLAIN;
                  again     = 1'b1;
               end
            end
            SCAN_DIGITS: begin
               if (is_oct && digit_total < 3) begin
                  octal_value = (octal_value << 3) + (b - CH_ZERO);
                  digit_vals[digit_total] = 3'(b - CH_ZERO);
                  digit_total++;
                  if (digit_total >= 3) close_escape();
               end else begin
                  close_escape();
                  again = 1'b1;
               end
            end
            default: begin
               scan_mode = SCAN_PLAIN;
               if (b == CH_BSL) scan_mode = SCAN_BSL;
               else take_literal(b);
            end
         endcase
      end
   endfunction

   // expected results of one accepted transaction
   function automatic void predict_item(logic [7:0] b, logic last);
      rsp_type r;
      step_out.delete();
      decode_byte(b);
      if (last) begin
         if (scan_mode == SCAN_BSL) place_byte(CH_BSL);
         else if (scan_mode == SCAN_DIGITS) close_escape();
         if (delay_valid) push_out(delay_byte, 1'b0);
         delay_valid = 1'b0;
         flush_held(1'b0);
         if (step_out.size() > 0) begin
            r          = step_out[$];
            r.out_last = 1'b1;
            step_out[step_out.size() - 1] = r;
         end
         scan_mode   = SCAN_PLAIN;
         digit_total = 0;
         octal_value = '0;
         esc_seen    = 1'b0;
         mark_on     = 1'b0;
      end
      foreach (step_out[i]) decoded_queue.push_back(step_out[i]);
   endfunction

   // ---------------- drivers ----------------

   // entered and left at a falling edge
   task automatic send_item(input logic [7:0] b, input logic last);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data.in_byte <= b;
      req_data.in_last <= last;
      req_valid        <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_item(b, last);
      items_sent++;
      if (last) lines_sent++;
      @(negedge clock);
   endtask

   task automatic send_line();
      foreach (line_buf[i]) send_item(line_buf[i], i == line_buf.size() - 1);
      line_buf.delete();
   endtask

   // result side stalls in bursts
   initial begin
      int stall;
      stall = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 10) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // result checker
   initial begin
      rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (decoded_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected result: byte %h last %b ovf %b",
                           rsp_data.out_byte, rsp_data.out_last, rsp_data.hold_overflow);
            end else begin
               want = decoded_queue.pop_front();
               results_checked++;
               if (rsp_data.hold_overflow) overflow_seen++;
               if (rsp_data.out_byte !== want.out_byte ||
                   rsp_data.out_last !== want.out_last ||
                   rsp_data.hold_overflow !== want.hold_overflow) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("mismatch #%0d: expected byte %h last %b ovf %b, got byte %h last %b ovf %b",
                              results_checked, want.out_byte, want.out_last,
                              want.hold_overflow, rsp_data.out_byte, rsp_data.out_last,
                              rsp_data.hold_overflow);
               end
            end
         end
      end
   end

   // ---------------- line builders ----------------

   function automatic void add_escape(int ndig);
      line_buf.push_back(CH_BSL);
      for (int i = 0; i < ndig; i++) line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
   endfunction

   function automatic void add_esc_code();
      line_buf.push_back(CH_BSL);
      if ($urandom_range(0, 1)) line_buf.push_back(CH_ZERO);
      line_buf.push_back(CH_ZERO + 8'd3);
      line_buf.push_back(CH_ZERO + 8'd3);
   endfunction

   // mixed tokens: plain bytes, escapes, escape codes, marks, stray backslashes
   function automatic void add_mixed(int ntok);
      int r;
      for (int t = 0; t < ntok; t++) begin
         r = $urandom_range(0, 99);
         if (r < 40) line_buf.push_back(8'($urandom_range(0, 255)));
         else if (r < 65) add_escape($urandom_range(1, 3));
         else if (r < 78) add_esc_code();
         else if (r < 90) line_buf.push_back(CH_K);
         else line_buf.push_back(CH_BSL);
      end
   endfunction

   // marked run long enough to fill the hold store
   function automatic void add_long_hold();
      add_esc_code();
      line_buf.push_back(CH_K);
      repeat ($urandom_range(28, 40)) line_buf.push_back(LETTER_A + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 1)) add_esc_code();
      if ($urandom_range(0, 1)) add_mixed($urandom_range(1, 4));
   endfunction

   // ---------------- tests ----------------

   task automatic test_plain_extremes();
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b1);
   endtask

   task automatic test_octal_escapes();
      // printable value re-emitted as text
      send_item(CH_BSL, 1'b0);
      send_item(CH_ZERO + 8'd1, 1'b0);
      send_item(CH_ZERO + 8'd0, 1'b0);
      send_item(CH_ZERO + 8'd1, 1'b0);
      // decoded backslash is sent raw
      send_item(CH_BSL, 1'b0);
      send_item(CH_ZERO + 8'd1, 1'b0);
      send_item(CH_ZERO + 8'd3, 1'b0);
      send_item(CH_ZERO + 8'd4, 1'b0);
      // value wraps modulo 256
      send_item(CH_BSL, 1'b0);
      send_item(CH_SEVEN, 1'b0);
      send_item(CH_SEVEN, 1'b0);
      send_item(CH_SEVEN, 1'b0);
      // backslash before a non-digit is dropped
      send_item(CH_BSL, 1'b0);
      send_item(LETTER_Q, 1'b0);
      // backslash at line end is kept
      send_item(CH_BSL, 1'b1);
   endtask

   task automatic test_retraction();
      // short escape ended by the mark, second mark, then a cut with digits open at line end
      send_item(CH_BSL, 1'b0);
      send_item(CH_ZERO + 8'd3, 1'b0);
      send_item(CH_ZERO + 8'd3, 1'b0);
      send_item(CH_K, 1'b0);
      send_item(LETTER_A, 1'b0);
      send_item(CH_K, 1'b0);
      send_item(LETTER_A + 8'd1, 1'b0);
      send_item(CH_BSL, 1'b0);
      send_item(CH_ZERO + 8'd3, 1'b0);
      send_item(CH_ZERO + 8'd3, 1'b1);
   endtask

   task automatic test_random_lines(input int n_items);
      int start;
      start = items_sent;
      while (items_sent - start < n_items) begin
         if ($urandom_range(0, 7) == 0) add_long_hold();
         else add_mixed($urandom_range(1, 12));
         send_line();
      end
   endtask

   task automatic test_back_to_back(input int n_items);
      idle_on = 1'b0;
      test_random_lines(n_items);
   endtask

   // ---------------- main sequence ----------------

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      idle_on   = 1'b1;
      items_sent      = 0;
      lines_sent      = 0;
      results_checked = 0;
      overflow_seen   = 0;
      mismatches      = 0;
      clear_decoder();
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_plain_extremes();
      test_octal_escapes();
      test_retraction();
      test_random_lines(350);
      test_back_to_back(55);

      req_valid <= 1'b0;
      while (decoded_queue.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("sent %0d bytes in %0d lines, checked %0d decoded bytes (%0d from hold overflow)",
               items_sent, lines_sent, results_checked, overflow_seen);
      $display("%0d mismatched or unexpected results", mismatches);
      if (mismatches == 0 && decoded_queue.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/oute_pkg.sv
hw/rtl/oute_hold_mem.sv
hw/rtl/oute_rsp_stage.sv
hw/rtl/oute_seq.sv
hw/rtl/octal_unescape_title_strip.sv
tb/testbench.sv
